FILE: rtl/cdq_pkg.sv
// Shared types and codes for the circular double-ended queue.
package cdq_pkg;

  // Input opcodes
  localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [2:0] OP_PUSH_REAR  = 3'd1;
  localparam logic [2:0] OP_POP_FRONT  = 3'd2;
  localparam logic [2:0] OP_POP_REAR   = 3'd3;
  localparam logic [2:0] OP_DUMP       = 3'd4;

  // Result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [2:0]         opcode;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] data;
    logic               last;
    logic [3:0]         occupancy;
  } out_item_t;

  typedef enum logic [2:0] {
    CMD_PUSH_FRONT,
    CMD_PUSH_REAR,
    CMD_POP_FRONT,
    CMD_POP_REAR,
    CMD_DUMP
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic signed [31:0] value;
  } cmd_t;

  typedef enum logic {
    BS_IDLE,
    BS_EMIT
  } back_state_t;

endpackage

FILE: rtl/cdq_front.sv
// Front end: accepts input transactions, decodes them and queues commands.
module cdq_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  cdq_pkg::in_item_t in_data,
  output logic              cmd_valid,
  output cdq_pkg::cmd_t     cmd,
  input  logic              cmd_take
);

  cdq_pkg::cmd_t cq_mem_r [2];
  logic          cq_wr_r, cq_wr_nxt;
  logic          cq_rd_r, cq_rd_nxt;
  logic [1:0]    cq_cnt_r, cq_cnt_nxt;
  logic          accept;
  logic          known;
  cdq_pkg::cmd_t dec_cmd;
  logic          do_wr;
  logic          do_rd;

  // Decode; unused opcodes are accepted and dropped
  always_comb begin
    known         = 1'b1;
    dec_cmd.value = in_data.value;
    dec_cmd.kind  = cdq_pkg::CMD_PUSH_FRONT;
    unique case (in_data.opcode)
      cdq_pkg::OP_PUSH_FRONT: dec_cmd.kind = cdq_pkg::CMD_PUSH_FRONT;
      cdq_pkg::OP_PUSH_REAR:  dec_cmd.kind = cdq_pkg::CMD_PUSH_REAR;
      cdq_pkg::OP_POP_FRONT:  dec_cmd.kind = cdq_pkg::CMD_POP_FRONT;
      cdq_pkg::OP_POP_REAR:   dec_cmd.kind = cdq_pkg::CMD_POP_REAR;
      cdq_pkg::OP_DUMP:       dec_cmd.kind = cdq_pkg::CMD_DUMP;
      default:                known        = 1'b0;
    endcase
  end

  assign in_full   = (cq_cnt_r == 2'd2);
  assign accept    = in_push && !in_full;
  assign cmd_valid = (cq_cnt_r != 2'd0);
  assign cmd       = cq_mem_r[cq_rd_r];
  assign do_wr     = accept && known;
  assign do_rd     = cmd_take && cmd_valid;

  always_comb begin
    cq_wr_nxt  = do_wr ? !cq_wr_r : cq_wr_r;
    cq_rd_nxt  = do_rd ? !cq_rd_r : cq_rd_r;
    cq_cnt_nxt = cq_cnt_r + {1'b0, do_wr} - {1'b0, do_rd};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cq_wr_r  <= 1'b0;
      cq_rd_r  <= 1'b0;
      cq_cnt_r <= 2'd0;
    end else begin
      cq_wr_r  <= cq_wr_nxt;
      cq_rd_r  <= cq_rd_nxt;
      cq_cnt_r <= cq_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      cq_mem_r[cq_wr_r] <= dec_cmd;
    end
  end

endmodule

FILE: rtl/cdq_back.sv
// Back end: deque state, element store, dump sequencer and result queue.
module cdq_back #(
  parameter int DEPTH = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cmd_valid,
  input  cdq_pkg::cmd_t      cmd,
  output logic               cmd_take,
  output logic               out_empty,
  input  logic               out_pop,
  output cdq_pkg::out_item_t out_data
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  function automatic logic [IW-1:0] idx_inc(input logic [IW-1:0] i);
    idx_inc = (i == IW'(DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [IW-1:0] idx_dec(input logic [IW-1:0] i);
    idx_dec = (i == '0) ? IW'(DEPTH - 1) : i - 1'b1;
  endfunction

  cdq_pkg::back_state_t state_r, state_nxt;
  logic [IW-1:0]        front_r, front_nxt;
  logic [IW-1:0]        rear_r, rear_nxt;
  logic [CW-1:0]        count_r, count_nxt;
  logic [CW-1:0]        left_r, left_nxt;
  logic [IW-1:0]        scan_r, scan_nxt;
  logic [3:0]           occ_r, occ_nxt;

  logic signed [31:0]   store [DEPTH];
  logic signed [31:0]   rd_data_r;
  logic                 mem_we, mem_re;
  logic [IW-1:0]        mem_waddr, mem_raddr;

  cdq_pkg::out_item_t   rq_mem_r [2];
  logic                 rq_wr_r, rq_rd_r;
  logic [1:0]           rq_cnt_r;
  logic                 rq_full, rq_we, rq_re;
  cdq_pkg::out_item_t   rq_wdata;

  logic                 can_go;
  logic                 is_full, is_empty;

  assign can_go   = cmd_valid && !rq_full;
  assign is_full  = (count_r == CW'(DEPTH));
  assign is_empty = (count_r == '0);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      cdq_pkg::BS_IDLE: begin
        if (can_go && !is_empty &&
            (cmd.kind == cdq_pkg::CMD_POP_FRONT || cmd.kind == cdq_pkg::CMD_POP_REAR ||
             cmd.kind == cdq_pkg::CMD_DUMP)) begin
          state_nxt = cdq_pkg::BS_EMIT;
        end
      end
      cdq_pkg::BS_EMIT: begin
        if (!rq_full && left_r == CW'(1)) begin
          state_nxt = cdq_pkg::BS_IDLE;
        end
      end
      default: state_nxt = cdq_pkg::BS_IDLE;
    endcase
  end

  // Datapath control
  always_comb begin
    cmd_take  = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = front_r;
    mem_re    = 1'b0;
    mem_raddr = front_r;
    rq_we     = 1'b0;
    rq_wdata  = '0;
    front_nxt = front_r;
    rear_nxt  = rear_r;
    count_nxt = count_r;
    left_nxt  = left_r;
    scan_nxt  = scan_r;
    occ_nxt   = occ_r;
    unique case (state_r)
      cdq_pkg::BS_IDLE: begin
        if (can_go) begin
          cmd_take = 1'b1;
          unique case (cmd.kind)
            cdq_pkg::CMD_PUSH_FRONT, cdq_pkg::CMD_PUSH_REAR: begin
              rq_we         = 1'b1;
              rq_wdata.last = 1'b1;
              if (is_full) begin
                rq_wdata.status    = cdq_pkg::ST_FULL;
                rq_wdata.occupancy = 4'(count_r);
              end else begin
                mem_we    = 1'b1;
                count_nxt = count_r + 1'b1;
                if (is_empty) begin
                  front_nxt = '0;
                  rear_nxt  = '0;
                  mem_waddr = '0;
                end else if (cmd.kind == cdq_pkg::CMD_PUSH_FRONT) begin
                  front_nxt = idx_dec(front_r);
                  mem_waddr = idx_dec(front_r);
                end else begin
                  rear_nxt  = idx_inc(rear_r);
                  mem_waddr = idx_inc(rear_r);
                end
                rq_wdata.status    = cdq_pkg::ST_OK;
                rq_wdata.occupancy = 4'(count_nxt);
              end
            end
            cdq_pkg::CMD_POP_FRONT, cdq_pkg::CMD_POP_REAR: begin
              if (is_empty) begin
                rq_we           = 1'b1;
                rq_wdata.status = cdq_pkg::ST_EMPTY;
                rq_wdata.last   = 1'b1;
              end else begin
                mem_re    = 1'b1;
                count_nxt = count_r - 1'b1;
                left_nxt  = CW'(1);
                occ_nxt   = 4'(count_nxt);
                if (cmd.kind == cdq_pkg::CMD_POP_FRONT) begin
                  mem_raddr = front_r;
                  front_nxt = idx_inc(front_r);
                end else begin
                  mem_raddr = rear_r;
                  rear_nxt  = idx_dec(rear_r);
                end
                if (count_r == CW'(1)) begin
                  front_nxt = '0;
                  rear_nxt  = '0;
                end
              end
            end
            cdq_pkg::CMD_DUMP: begin
              if (is_empty) begin
                rq_we           = 1'b1;
                rq_wdata.status = cdq_pkg::ST_EMPTY;
                rq_wdata.last   = 1'b1;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = front_r;
                scan_nxt  = idx_inc(front_r);
                left_nxt  = count_r;
                occ_nxt   = 4'(count_r);
              end
            end
            default: ;
          endcase
        end
      end
      cdq_pkg::BS_EMIT: begin
        // read data waits in rd_data_r until the result queue has room
        if (!rq_full) begin
          rq_we              = 1'b1;
          rq_wdata.status    = cdq_pkg::ST_OK;
          rq_wdata.data      = rd_data_r;
          rq_wdata.last      = (left_r == CW'(1));
          rq_wdata.occupancy = occ_r;
          if (left_r != CW'(1)) begin
            mem_re    = 1'b1;
            mem_raddr = scan_r;
            scan_nxt  = idx_inc(scan_r);
            left_nxt  = left_r - 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cdq_pkg::BS_IDLE;
      front_r <= '0;
      rear_r  <= '0;
      count_r <= '0;
      left_r  <= '0;
      scan_r  <= '0;
      occ_r   <= '0;
    end else begin
      state_r <= state_nxt;
      front_r <= front_nxt;
      rear_r  <= rear_nxt;
      count_r <= count_nxt;
      left_r  <= left_nxt;
      scan_r  <= scan_nxt;
      occ_r   <= occ_nxt;
    end
  end

  // Element store, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      store[mem_waddr] <= cmd.value;
    end
    if (mem_re) begin
      rd_data_r <= store[mem_raddr];
    end
  end

  // Two-entry result queue
  assign rq_full   = (rq_cnt_r == 2'd2);
  assign out_empty = (rq_cnt_r == 2'd0);
  assign rq_re     = out_pop && !out_empty;
  assign out_data  = rq_mem_r[rq_rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rq_wr_r  <= 1'b0;
      rq_rd_r  <= 1'b0;
      rq_cnt_r <= 2'd0;
    end else begin
      rq_wr_r  <= rq_we ? !rq_wr_r : rq_wr_r;
      rq_rd_r  <= rq_re ? !rq_rd_r : rq_rd_r;
      rq_cnt_r <= rq_cnt_r + {1'b0, rq_we} - {1'b0, rq_re};
    end
  end

  always_ff @(posedge clk) begin
    if (rq_we) begin
      rq_mem_r[rq_wr_r] <= rq_wdata;
    end
  end

endmodule

FILE: rtl/circular_double_ended_queue.sv
// Push, full and empty results pass the command queue, then the result queue; pops also pass
//   the registered read of the element store. Throughput: one push or rejected transaction per
//   cycle while the result queue has room; a pop or dump holds the back end to its last result.
// A two-entry command queue and a two-entry result queue let each side stall on its own.
// Reset (rst_n low, synchronous) clears indices, count and both queues; the element store
//   is not cleared and needs no clearing pass.
module circular_double_ended_queue #(
  parameter int DEPTH = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  cdq_pkg::in_item_t  in_data,
  output logic               out_empty,
  input  logic               out_pop,
  output cdq_pkg::out_item_t out_data
);

  // Command channel between the decoder and the executing back end.
  logic          cmd_valid;
  logic          cmd_take;
  cdq_pkg::cmd_t cmd;

  // Front: takes every transaction while its queue has room; unused opcodes
  // vanish here and never reach the back end.
  cdq_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_data   (in_data),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take)
  );

  // Back: owns front/rear indices, count and the element store. It only
  // takes a command when the result queue has a free slot, so a result
  // is never dropped; pops and dumps then stream out of the store.
  cdq_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  // Back end only consumes a command that is really there.
  a_take_valid : assert property (@(posedge clk) disable iff (!rst_n)
    cmd_take |-> cmd_valid)
    else $error("command taken from an empty command queue");

  // Reset leaves both queues empty.
  a_reset_clear : assert property (@(posedge clk)
    !rst_n |=> (out_empty && !in_full))
    else $error("queues not empty after reset");

  // A rejected or empty result always closes its transaction.
  a_err_last : assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_data.status != cdq_pkg::ST_OK) |-> out_data.last)
    else $error("error status without last flag");

  // Only the three defined status codes ever leave the block.
  a_status_code : assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_data.status == cdq_pkg::ST_OK ||
                    out_data.status == cdq_pkg::ST_FULL ||
                    out_data.status == cdq_pkg::ST_EMPTY))
    else $error("undefined status code on result");
`endif

endmodule
